@@ src/assert_macros.svh @@
// Assertion helpers for the ordered list engine.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that c holds in the same cycle as a.
`define ASSERT_SAME(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: %m");

// Check that c holds in the cycle after a.
`define ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: %m");

`else

`define ASSERT_SAME(label, a, c)
`define ASSERT_NEXT(label, a, c)

`endif

`endif

@@ src/bole_pkg.sv @@
`timescale 1ns / 1ps

package bole_pkg;

    // Request codes
    localparam logic [2:0] REQ_INSERT     = 3'd0;
    localparam logic [2:0] REQ_DELETE     = 3'd1;
    localparam logic [2:0] REQ_FIND_FIRST = 3'd2;
    localparam logic [2:0] REQ_FIND_ALL   = 3'd3;
    localparam logic [2:0] REQ_LIST_ALL   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Most results one request may return
    localparam int RESULT_LIMIT = 16;
    localparam int HIT_W        = 5;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the request on the input port
        logic step;     // examine the head cell and rotate the row
        logic finish;   // load the closing result of a scan
    } bole_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;  // output register can take a result this cycle
        logic scan_req;   // request on the input needs a scan of the row
        logic scan_last;  // current scan position is the final element
    } bole_sts_t;

endpackage

@@ src/bounded_ordered_list_engine.sv @@
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values, head at position 0.
// Request channel (in_valid, in_stall): req_type, position, value. Result
// channel (out_valid, out_stall): value_res, position_res, found, status,
// count, last. Every request returns one or more results; last marks the end.
// Insert, delete and every request that needs no search (rejects, empty list,
// unknown codes) answer at once: the result is valid the cycle after accept.
// Find first, find all and list all walk the row: while the result register
// has room, the filled cells rotate one place per cycle past the head cell,
// which is compared and reported. The next request is taken only after the
// closing result of the search has been loaded.
// A full walk rotates the row by the element count, back to its original order.
// Find all and list all return at most one result per cycle, at most 16 per
// request. The result sits in an output register; while out_stall is high the
// result holds and the walk pauses, and no new request is accepted.
// Reset empties the list; stored values need no clearing, since only cells
// below the count are ever read.
`include "assert_macros.svh"

module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value_res,
    output logic [3:0]         position_res,
    output logic               found,
    output logic [1:0]         status,
    output logic [4:0]         count,
    output logic               last
);

    bole_cmd_t cmd;
    bole_sts_t sts;

    bole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    bole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .position     (position),
        .value        (value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .value_res    (value_res),
        .position_res (position_res),
        .found        (found),
        .status       (status),
        .count        (count),
        .last         (last)
    );

    // A request needing no search gives its only result next cycle
    `ASSERT_NEXT(a_direct_result, cmd.accept && !sts.scan_req, out_valid && last)
    // Closing a scan always loads the final result
    `ASSERT_NEXT(a_finish_last, cmd.finish, out_valid && last)
    // No request is taken while a scan is in flight
    `ASSERT_SAME(a_busy_stall, cmd.step || cmd.finish, in_stall && !cmd.accept)

endmodule

@@ src/bole_ctrl.sv @@
`timescale 1ns / 1ps

module bole_ctrl
    import bole_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  bole_sts_t sts,
    output bole_cmd_t cmd,
    output logic      in_stall
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Decode state into commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && sts.slot_free)
                begin
                    cmd.accept = 1'b1;
                    if (sts.scan_req)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.slot_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (sts.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Take requests only when idle and the result has room
    assign in_stall = !((state_reg == S_IDLE) && sts.slot_free);

endmodule

@@ src/bole_dp.sv @@
`timescale 1ns / 1ps

module bole_dp
    import bole_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bole_cmd_t          cmd,
    output bole_sts_t          sts,
    input  logic [2:0]         req_type,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] value_res,
    output logic [3:0]         position_res,
    output logic               found,
    output logic [1:0]         status,
    output logic [4:0]         count,
    output logic               last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Cell row and element count
    logic [31:0]   cell_reg  [CAPACITY];
    logic [31:0]   cell_next [CAPACITY];
    logic [31:0]   prev_w    [CAPACITY];
    logic [31:0]   succ_w    [CAPACITY];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] cnt_m1;

    // Scan state
    logic             list_reg;
    logic             first_reg;
    logic [31:0]      sval_reg;
    logic [IW-1:0]    idx_reg;
    logic [HIT_W-1:0] hits_reg;
    logic             pend_v_reg;
    logic [31:0]      pend_val_reg;
    logic [3:0]       pend_pos_reg;
    logic [HIT_W-1:0] hit_lim;
    logic             hit;
    logic             take;
    logic             push_mid;

    // Request decode
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          ins_ok;
    logic          del_ok;
    logic          scan_req;
    logic [1:0]    dir_status;
    logic [31:0]   dir_value;
    logic [3:0]    dir_pos;

    // Output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_load;
    logic [31:0] out_value_reg;
    logic [31:0] out_value_next;
    logic [3:0]  out_pos_reg;
    logic [3:0]  out_pos_next;
    logic        out_found_reg;
    logic        out_found_next;
    logic [1:0]  out_status_reg;
    logic [1:0]  out_status_next;
    logic [4:0]  out_count_reg;
    logic [4:0]  out_count_next;
    logic        out_last_reg;
    logic        out_last_next;

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign cnt_m1  = count_reg - CW'(1);

    // Check the request against the list and form a single result
    always_comb
    begin
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        scan_req   = 1'b0;
        dir_status = ST_OK;
        dir_value  = value;
        dir_pos    = position[3:0];
        unique case (req_type) inside
            REQ_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    dir_status = ST_RANGE;
                end
                else if (count_reg == CAP_C)
                begin
                    dir_status = ST_FULL;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            REQ_DELETE:
            begin
                if (count_reg == '0)
                begin
                    dir_status = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    dir_status = ST_RANGE;
                end
                else
                begin
                    del_ok = 1'b1;
                end
            end
            REQ_FIND_FIRST, REQ_FIND_ALL:
            begin
                dir_pos  = 4'd0;
                scan_req = (count_reg != '0);
            end
            REQ_LIST_ALL:
            begin
                dir_value  = 32'd0;
                dir_pos    = 4'd0;
                dir_status = ST_EMPTY;
                scan_req   = (count_reg != '0);
            end
            default:
            begin
            end
        endcase
    end

    // Wire up neighbors of each cell; the row ends hold themselves
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_nbr
        if (g > 0)
        begin : g_prev
            assign prev_w[g] = cell_reg[g-1];
        end
        else
        begin : g_prev0
            assign prev_w[g] = cell_reg[g];
        end
        if (g < CAPACITY - 1)
        begin : g_succ
            assign succ_w[g] = cell_reg[g+1];
        end
        else
        begin : g_succn
            assign succ_w[g] = cell_reg[g];
        end
    end

    // Shift for insert and delete, rotate the filled part during a scan
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.accept && ins_ok)
            begin
                if (PW'(i) == pos_ext)
                begin
                    cell_next[i] = value;
                end
                else if (PW'(i) > pos_ext)
                begin
                    cell_next[i] = prev_w[i];
                end
            end
            else if (cmd.accept && del_ok)
            begin
                if (PW'(i) >= pos_ext)
                begin
                    cell_next[i] = succ_w[i];
                end
            end
            else if (cmd.step)
            begin
                if (CW'(i) == cnt_m1)
                begin
                    cell_next[i] = cell_reg[0];
                end
                else if (CW'(i) < cnt_m1)
                begin
                    cell_next[i] = succ_w[i];
                end
            end
        end
    end

    // Update the element count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.accept && ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.accept && del_ok)
        begin
            count_next = cnt_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    // Compare the head cell against the search value; under list all every cell is a hit
    assign hit_lim  = first_reg ? HIT_W'(1) : HIT_W'(RESULT_LIMIT);
    assign hit      = list_reg || (cell_reg[0] == sval_reg);
    assign take     = hit && (hits_reg < hit_lim);
    assign push_mid = take && pend_v_reg;

    // Hold scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            list_reg   <= 1'b0;
            first_reg  <= 1'b0;
            idx_reg    <= '0;
            hits_reg   <= '0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.accept)
            begin
                list_reg   <= (req_type == REQ_LIST_ALL);
                first_reg  <= (req_type == REQ_FIND_FIRST);
                idx_reg    <= '0;
                hits_reg   <= '0;
                pend_v_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (take)
                begin
                    hits_reg   <= hits_reg + HIT_W'(1);
                    pend_v_reg <= 1'b1;
                end
            end
        end
    end

    // Capture the search value and the newest hit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sval_reg <= value;
        end
        if (cmd.step && take)
        begin
            pend_val_reg <= list_reg ? cell_reg[0] : sval_reg;
            pend_pos_reg <= 4'(idx_reg);
        end
    end

    // Select what goes into the output register
    always_comb
    begin
        out_load        = 1'b1;
        out_value_next  = dir_value;
        out_pos_next    = dir_pos;
        out_found_next  = 1'b0;
        out_status_next = dir_status;
        out_count_next  = 5'(count_next);
        out_last_next   = 1'b1;
        if (cmd.accept && !scan_req)
        begin
            out_load = 1'b1;
        end
        else if (cmd.step && push_mid)
        begin
            out_value_next  = pend_val_reg;
            out_pos_next    = pend_pos_reg;
            out_found_next  = 1'b1;
            out_status_next = ST_OK;
            out_count_next  = 5'(count_reg);
            out_last_next   = 1'b0;
        end
        else if (cmd.finish)
        begin
            out_value_next  = pend_v_reg ? pend_val_reg : sval_reg;
            out_pos_next    = pend_v_reg ? pend_pos_reg : 4'd0;
            out_found_next  = pend_v_reg;
            out_status_next = ST_OK;
            out_count_next  = 5'(count_reg);
            out_last_next   = 1'b1;
        end
        else
        begin
            out_load = 1'b0;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= out_value_next;
            out_pos_reg    <= out_pos_next;
            out_found_reg  <= out_found_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Report status
    assign sts.slot_free = !out_valid_reg || !out_stall;
    assign sts.scan_req  = scan_req;
    assign sts.scan_last = (CW'(idx_reg) == cnt_m1);

    assign out_valid    = out_valid_reg;
    assign value_res    = out_value_reg;
    assign position_res = out_pos_reg;
    assign found        = out_found_reg;
    assign status       = out_status_reg;
    assign count        = out_count_reg;
    assign last         = out_last_reg;

endmodule
